// ----- design/varc_pkg.sv -----
package varc_pkg;

  localparam int LIST_DEPTH  = 16;
  localparam int RETRY_LIMIT = 7;
  localparam int CNT_W       = $clog2(LIST_DEPTH);
  localparam int RETRY_W     = $clog2(RETRY_LIMIT + 1);
  localparam int CFG_IDX_W   = 1;

  typedef enum logic [2:0] {
    REQ_RESPONSE = 3'd0,
    REQ_PLAY     = 3'd1,
    REQ_STOP     = 3'd2,
    REQ_CLEAR    = 3'd3,
    REQ_STATUS   = 3'd4,
    REQ_VERSION  = 3'd5,
    REQ_VOLUME   = 3'd6
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANN_ADDR = 1'b0,
    CFG_REC_ADDR = 1'b1
  } cfg_idx_e;

  localparam logic [7:0] CMD_NONE    = 8'h00;
  localparam logic [7:0] CMD_PLAY    = 8'h01;
  localparam logic [7:0] CMD_STOP    = 8'h02;
  localparam logic [7:0] CMD_VERSION = 8'h04;
  localparam logic [7:0] CMD_STATUS  = 8'h05;
  localparam logic [7:0] CMD_VOLUME  = 8'h06;
  localparam logic [7:0] REC_START   = 8'h07;
  localparam logic [7:0] REC_STOP    = 8'h08;

  localparam logic [7:0] ANN_IDLE    = 8'd0;
  localparam logic [7:0] ANN_PLAYING = 8'd1;
  localparam logic [7:0] ANN_STOPPED = 8'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  source_device;
    logic [7:0]  response_code;
    logic [7:0]  response_byte_one;
    logic [7:0]  response_byte_two;
    logic [15:0] entry_code;
    logic        list_restart;
    logic        urgent_active;
  } req_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_code;
    logic [15:0] payload_word;
    logic        payload_valid;
    logic        last_of_run;
    logic        busy_res;
    logic        recording;
    logic        emergency_stop;
  } res_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           value;
  } cfg_t;

endpackage

// ----- design/varc_intf.sv -----
interface varc_req_if;
  logic          valid;
  logic          ready;
  varc_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface varc_res_if;
  logic          valid;
  logic          ready;
  varc_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface varc_cfg_if;
  logic          valid;
  logic          ready;
  varc_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/voice_announcer_command_retry.sv -----
// Command-and-retry controller for a voice announcer. Every input item gives
// one or more result items, the final one marked by last_of_run. Items other
// than a play command leave through a single output register, so a new item
// is taken once that register is free. A play command reads the play list
// from a 16-word synchronous RAM, one word per cycle while the output is not
// stalled, and emits one result per stored entry (up to LIST_DEPTH-1); no new
// item is taken until its last word is in the output register. Configuration
// writes are always accepted and are registered.
module voice_announcer_command_retry (
  input  logic         clk_i,
  input  logic         rst_ni,
  varc_req_if.sink     req_i,
  varc_res_if.source   res_o,
  varc_cfg_if.sink     cfg_i
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_STREAM = 2'b10
  } ctrl_e;

  typedef enum logic [3:0] {
    T_IDLE    = 4'b0001,
    T_PLAY    = 4'b0010,
    T_PRESTOP = 4'b0100,
    T_STOP    = 4'b1000
  } task_e;

  localparam int CW = varc_pkg::CNT_W;
  localparam int RW = varc_pkg::RETRY_W;

  ctrl_e                st_q, st_d;
  task_e                task_q, task_d;
  logic [7:0]           ann_q, ann_d;
  logic [RW-1:0]        retry_q, retry_d;
  logic                 wait_q, wait_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 rec_q, rec_d;
  logic [7:0]           ann_addr_q, rec_addr_q;

  logic                 out_vld_q, out_vld_d;
  varc_pkg::res_t       out_q, out_d;
  logic                 emerg_q, emerg_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        last_q, last_d;

  logic [15:0]          mem [varc_pkg::LIST_DEPTH];
  logic [15:0]          rdata_q;
  logic [CW-1:0]        rd_addr;
  logic                 wr_en;
  logic [CW-1:0]        wr_addr;

  logic                 slot_free;
  logic                 in_acc;
  logic [7:0]           send;
  logic                 emerg;
  logic [15:0]          word;
  logic                 wvalid;
  logic [CW-1:0]        base;
  logic                 busy_d;

  assign slot_free   = !out_vld_q || res_o.ready;
  assign req_i.ready = (st_q == S_IDLE) && slot_free;
  assign in_acc      = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_q;

  always_comb begin
    st_d      = st_q;
    task_d    = task_q;
    ann_d     = ann_q;
    retry_d   = retry_q;
    wait_d    = wait_q;
    cnt_d     = cnt_q;
    rec_d     = rec_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    emerg_d   = emerg_q;
    idx_d     = idx_q;
    last_d    = last_q;
    rd_addr   = idx_q;
    wr_en     = 1'b0;
    wr_addr   = cnt_q;
    send      = varc_pkg::CMD_NONE;
    emerg     = 1'b0;
    word      = '0;
    wvalid    = 1'b0;
    base      = cnt_q;
    busy_d    = 1'b0;

    if (res_o.ready) out_vld_d = 1'b0;

    unique case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (req_i.data.req_type)
            varc_pkg::REQ_RESPONSE: begin
              if (req_i.data.source_device == ann_addr_q) begin
                if (req_i.data.response_code == varc_pkg::CMD_STATUS) begin
                  ann_d = req_i.data.response_byte_two;
                  if (req_i.data.urgent_active && req_i.data.response_byte_one != 8'd0) begin
                    task_d  = T_STOP;
                    retry_d = RW'(varc_pkg::RETRY_LIMIT);
                    wait_d  = 1'b0;
                    cnt_d   = '0;
                    emerg   = 1'b1;
                  end
                end else if (req_i.data.response_code == varc_pkg::CMD_STOP) begin
                  ann_d = varc_pkg::ANN_STOPPED;
                end
                // task machine steps once per announcer response
                unique case (task_d)
                  T_PLAY: begin
                    if (ann_d != varc_pkg::ANN_IDLE) begin
                      task_d = T_IDLE;
                    end else if (wait_d) begin
                      wait_d = 1'b0;
                    end else if (retry_d != '0) begin
                      retry_d = retry_d - RW'(1);
                      wait_d  = 1'b1;
                      send    = varc_pkg::CMD_PLAY;
                    end else begin
                      task_d = T_IDLE;
                    end
                  end
                  T_PRESTOP: begin
                    if (ann_d != varc_pkg::ANN_PLAYING) begin
                      task_d  = T_PLAY;
                      retry_d = RW'(varc_pkg::RETRY_LIMIT);
                      wait_d  = 1'b0;
                    end else if (wait_d) begin
                      wait_d = 1'b0;
                    end else if (retry_d != '0) begin
                      retry_d = retry_d - RW'(1);
                      wait_d  = 1'b1;
                      send    = varc_pkg::CMD_STOP;
                    end else begin
                      task_d  = T_PLAY;
                      retry_d = RW'(1);
                      wait_d  = 1'b0;
                    end
                  end
                  T_STOP: begin
                    if (ann_d != varc_pkg::ANN_PLAYING) begin
                      task_d = T_IDLE;
                    end else if (wait_d) begin
                      wait_d = 1'b0;
                    end else if (retry_d != '0) begin
                      retry_d = retry_d - RW'(1);
                      wait_d  = 1'b0;
                      send    = varc_pkg::CMD_STOP;
                    end else begin
                      task_d = T_IDLE;
                    end
                  end
                  default: ;
                endcase
              end else if (req_i.data.source_device == rec_addr_q) begin
                if (req_i.data.response_code == varc_pkg::REC_START) begin
                  rec_d = 1'b1;
                end else if (req_i.data.response_code == varc_pkg::REC_STOP) begin
                  rec_d = 1'b0;
                end
              end
            end
            varc_pkg::REQ_PLAY: begin
              base = req_i.data.list_restart ? '0 : cnt_q;
              cnt_d = base;
              if (base < CW'(varc_pkg::LIST_DEPTH - 1)) begin
                wr_en   = 1'b1;
                wr_addr = base;
                cnt_d   = base + CW'(1);
              end
              task_d  = T_PRESTOP;
              retry_d = RW'(varc_pkg::RETRY_LIMIT);
              wait_d  = 1'b0;
            end
            varc_pkg::REQ_STOP: begin
              task_d  = T_STOP;
              retry_d = RW'(varc_pkg::RETRY_LIMIT);
              wait_d  = 1'b0;
            end
            varc_pkg::REQ_CLEAR: begin
              task_d = T_IDLE;
              ann_d  = varc_pkg::ANN_IDLE;
              cnt_d  = '0;
            end
            varc_pkg::REQ_STATUS:  send = varc_pkg::CMD_STATUS;
            varc_pkg::REQ_VERSION: send = varc_pkg::CMD_VERSION;
            varc_pkg::REQ_VOLUME: begin
              send   = varc_pkg::CMD_VOLUME;
              word   = {8'd0, req_i.data.entry_code[7:0]};
              wvalid = 1'b1;
            end
            default: ;
          endcase

          busy_d  = (task_d != T_IDLE) || (ann_d == varc_pkg::ANN_PLAYING);
          emerg_d = emerg;

          if (send == varc_pkg::CMD_PLAY && cnt_d != '0) begin
            // list words come from the RAM over the next cycles
            st_d    = S_STREAM;
            idx_d   = '0;
            rd_addr = '0;
            last_d  = cnt_d - CW'(1);
          end else begin
            out_vld_d           = 1'b1;
            out_d.send_valid    = (send != varc_pkg::CMD_NONE);
            out_d.send_code     = send;
            out_d.payload_word  = word;
            out_d.payload_valid = wvalid;
            out_d.last_of_run   = 1'b1;
            out_d.busy_res      = busy_d;
            out_d.recording     = rec_d;
            out_d.emergency_stop = emerg;
          end
        end
      end
      S_STREAM: begin
        if (slot_free) begin
          out_vld_d            = 1'b1;
          out_d.send_valid     = 1'b1;
          out_d.send_code      = varc_pkg::CMD_PLAY;
          out_d.payload_word   = rdata_q;
          out_d.payload_valid  = 1'b1;
          out_d.last_of_run    = (idx_q == last_q);
          out_d.busy_res       = (task_q != T_IDLE) || (ann_q == varc_pkg::ANN_PLAYING);
          out_d.recording      = rec_q;
          out_d.emergency_stop = emerg_q;
          idx_d   = idx_q + CW'(1);
          rd_addr = idx_q + CW'(1);
          if (idx_q == last_q) st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= req_i.data.entry_code;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    idx_q  <= idx_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      task_q     <= T_IDLE;
      ann_q      <= varc_pkg::ANN_IDLE;
      retry_q    <= '0;
      wait_q     <= 1'b0;
      cnt_q      <= '0;
      rec_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      emerg_q    <= 1'b0;
      ann_addr_q <= 8'd1;
      rec_addr_q <= 8'd2;
    end else begin
      st_q      <= st_d;
      task_q    <= task_d;
      ann_q     <= ann_d;
      retry_q   <= retry_d;
      wait_q    <= wait_d;
      cnt_q     <= cnt_d;
      rec_q     <= rec_d;
      out_vld_q <= out_vld_d;
      emerg_q   <= emerg_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.data.index)
          varc_pkg::CFG_ANN_ADDR: ann_addr_q <= cfg_i.data.value;
          varc_pkg::CFG_REC_ADDR: rec_addr_q <= cfg_i.data.value;
          default: ;
        endcase
      end
    end
  end

  a_stream_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_STREAM |-> idx_q <= last_q)
    else $error("stream index ran past list end");

  a_stream_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_STREAM && slot_free && idx_q == last_q) |=> st_q == S_IDLE)
    else $error("stream did not end after last word");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!out_vld_q || res_o.ready))
    else $error("item accepted while result still pending");

  a_retry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    retry_q <= RW'(varc_pkg::RETRY_LIMIT))
    else $error("retry counter out of range");

  a_list_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(varc_pkg::LIST_DEPTH - 1))
    else $error("play list count above cap");

endmodule

// ----- sim/tb_announcer_pkg.sv -----
`timescale 1ns / 100ps

package tb_announcer_pkg;
  import varc_pkg::*;

  typedef enum logic [1:0] {
    TS_IDLE    = 2'd0,
    TS_PLAY    = 2'd1,
    TS_PRESTOP = 2'd2,
    TS_STOP    = 2'd3
  } task_e;

  // request type outside the defined set, and a response code the block does not know
  localparam logic [2:0] REQ_UNUSED  = 3'd7;
  localparam logic [7:0] RSP_UNKNOWN = 8'h33;

  class announcer_cmd_model;
    logic [7:0]         ann_addr;
    logic [7:0]         rec_addr;
    task_e              tstate;
    logic [7:0]         ann_state;
    logic [RETRY_W-1:0] retries;
    logic               wait_flag;
    logic [CNT_W:0]     list_count;
    logic [15:0]        play_list [LIST_DEPTH];
    logic               rec_flag;

    res_t cmd_results_q [$];
    int   errors;
    int   items_seen;
    int   results_seen;
    int   play_cmds;
    int   emerg_stops;

    function new();
      ann_addr   = 8'd1;
      rec_addr   = 8'd2;
      tstate     = TS_IDLE;
      ann_state  = ANN_IDLE;
      retries    = '0;
      wait_flag  = 1'b0;
      list_count = '0;
      rec_flag   = 1'b0;
      foreach (play_list[i]) play_list[i] = '0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [7:0] value);
      if (idx == CFG_ANN_ADDR) ann_addr = value;
      else rec_addr = value;
    endfunction

    function int pending();
      return cmd_results_q.size();
    endfunction

    function void arm(task_e st);
      tstate    = st;
      retries   = RETRY_W'(RETRY_LIMIT);
      wait_flag = 1'b0;
    endfunction

    // one step of the retry machine, returns the command to send
    function logic [7:0] advance();
      case (tstate)
        TS_PLAY: begin
          if (ann_state != ANN_IDLE) begin
            tstate = TS_IDLE;
            return CMD_NONE;
          end
          if (wait_flag) begin
            wait_flag = 1'b0;
            return CMD_NONE;
          end
          if (retries != 0) begin
            retries--;
            wait_flag = 1'b1;
            return CMD_PLAY;
          end
          tstate = TS_IDLE;
          return CMD_NONE;
        end
        TS_PRESTOP: begin
          if (ann_state != ANN_PLAYING) begin
            arm(TS_PLAY);
            return CMD_NONE;
          end
          if (wait_flag) begin
            wait_flag = 1'b0;
            return CMD_NONE;
          end
          if (retries != 0) begin
            retries--;
            wait_flag = 1'b1;
            return CMD_STOP;
          end
          // stop retries used up: one last play attempt
          tstate    = TS_PLAY;
          retries   = RETRY_W'(1);
          wait_flag = 1'b0;
          return CMD_NONE;
        end
        TS_STOP: begin
          if (ann_state != ANN_PLAYING) begin
            tstate = TS_IDLE;
            return CMD_NONE;
          end
          if (wait_flag) begin
            wait_flag = 1'b0;
            return CMD_NONE;
          end
          if (retries != 0) begin
            retries--;
            wait_flag = 1'b0;
            return CMD_STOP;
          end
          tstate = TS_IDLE;
          return CMD_NONE;
        end
        default: return CMD_NONE;
      endcase
    endfunction

    function res_t make_res(logic v, logic [7:0] code, logic [15:0] word, logic wv,
                            logic last, logic emerg);
      res_t x;
      x.send_valid     = v;
      x.send_code      = code;
      x.payload_word   = word;
      x.payload_valid  = wv;
      x.last_of_run    = last;
      x.busy_res       = (tstate != TS_IDLE) || (ann_state == ANN_PLAYING);
      x.recording      = rec_flag;
      x.emergency_stop = emerg;
      return x;
    endfunction

    function void accept_event(req_t r);
      logic [7:0]  cmd;
      logic        emerg;
      logic [15:0] word;
      logic        wv;
      cmd   = CMD_NONE;
      emerg = 1'b0;
      word  = '0;
      wv    = 1'b0;
      items_seen++;
      case (r.req_type)
        REQ_RESPONSE: begin
          // announcer wins when both addresses match
          if (r.source_device == ann_addr) begin
            if (r.response_code == CMD_STATUS) begin
              ann_state = r.response_byte_two;
              if (r.urgent_active && r.response_byte_one != 8'd0) begin
                arm(TS_STOP);
                list_count = '0;
                emerg      = 1'b1;
              end
            end else if (r.response_code == CMD_STOP) begin
              ann_state = ANN_STOPPED;
            end
            cmd = advance();
          end else if (r.source_device == rec_addr) begin
            if (r.response_code == REC_START) rec_flag = 1'b1;
            else if (r.response_code == REC_STOP) rec_flag = 1'b0;
          end
        end
        REQ_PLAY: begin
          if (r.list_restart) list_count = '0;
          if (list_count < LIST_DEPTH - 1) begin
            play_list[list_count[CNT_W-1:0]] = r.entry_code;
            list_count++;
          end
          arm(TS_PRESTOP);
        end
        REQ_STOP: arm(TS_STOP);
        REQ_CLEAR: begin
          tstate     = TS_IDLE;
          ann_state  = ANN_IDLE;
          list_count = '0;
        end
        REQ_STATUS:  cmd = CMD_STATUS;
        REQ_VERSION: cmd = CMD_VERSION;
        REQ_VOLUME: begin
          cmd  = CMD_VOLUME;
          word = {8'h00, r.entry_code[7:0]};
          wv   = 1'b1;
        end
        default: ;
      endcase

      if (emerg) emerg_stops++;
      if (cmd == CMD_PLAY) play_cmds++;

      if (cmd == CMD_PLAY && list_count != 0) begin
        for (int i = 0; i < list_count; i++)
          cmd_results_q.push_back(make_res(1'b1, cmd, play_list[i], 1'b1,
                                           (i + 1 == list_count), emerg));
      end else if (cmd != CMD_NONE) begin
        cmd_results_q.push_back(make_res(1'b1, cmd, word, wv, 1'b1, emerg));
      end else begin
        cmd_results_q.push_back(make_res(1'b0, CMD_NONE, '0, 1'b0, 1'b1, emerg));
      end
    endfunction

    function void cmp(string fname, logic [15:0] exp_v, logic [15:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_cmd(res_t got);
      res_t want;
      results_seen++;
      if (cmd_results_q.size() == 0) begin
        $error("result item with nothing outstanding: 0x%0h", got);
        errors++;
        return;
      end
      want = cmd_results_q.pop_front();
      cmp("send_valid",     16'(want.send_valid),     16'(got.send_valid));
      cmp("send_code",      16'(want.send_code),      16'(got.send_code));
      cmp("payload_word",   want.payload_word,        got.payload_word);
      cmp("payload_valid",  16'(want.payload_valid),  16'(got.payload_valid));
      cmp("last_of_run",    16'(want.last_of_run),    16'(got.last_of_run));
      cmp("busy_res",       16'(want.busy_res),       16'(got.busy_res));
      cmp("recording",      16'(want.recording),      16'(got.recording));
      cmp("emergency_stop", 16'(want.emergency_stop), 16'(got.emergency_stop));
    endfunction
  endclass

endpackage

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import varc_pkg::*;
  import tb_announcer_pkg::*;

  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 80;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  varc_req_if req_if ();
  varc_res_if res_if ();
  varc_cfg_if cfg_if ();

  voice_announcer_command_retry i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  announcer_cmd_model model = new();

  int n_sent;
  int hold_req;
  int hold_left;
  int stall_left;
  bit calm;

  // result side: random stalls per item, plus a long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (rst_ni && res_if.valid && res_if.ready) begin
        model.check_cmd(res_if.data);
        stall_left = calm ? 0 : $urandom_range(0, 3);
      end
      if (!rst_ni) begin
        res_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  function automatic req_t rnd_req(logic [2:0] kind);
    req_t r;
    r.req_type          = kind;
    r.source_device     = 8'($urandom);
    r.response_code     = 8'($urandom);
    r.response_byte_one = 8'($urandom);
    r.response_byte_two = 8'($urandom);
    r.entry_code        = 16'($urandom);
    r.list_restart      = 1'($urandom);
    r.urgent_active     = 1'($urandom);
    return r;
  endfunction

  function automatic req_t ann_resp(logic [7:0] code, logic [7:0] b1, logic [7:0] b2,
                                    logic urgent);
    req_t r;
    r = rnd_req(REQ_RESPONSE);
    r.source_device     = model.ann_addr;
    r.response_code     = code;
    r.response_byte_one = b1;
    r.response_byte_two = b2;
    r.urgent_active     = urgent;
    return r;
  endfunction

  function automatic req_t play_req(logic [15:0] code, logic restart);
    req_t r;
    r = rnd_req(REQ_PLAY);
    r.entry_code   = code;
    r.list_restart = restart;
    return r;
  endfunction

  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_ann_state();
    case ($urandom_range(0, 5))
      3:       return ANN_PLAYING;
      4:       return ANN_STOPPED;
      5:       return 8'($urandom);
      default: return ANN_IDLE;
    endcase
  endfunction

  // valid stays high after acceptance; the next call or drain() moves it
  task automatic send_item(input req_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    model.accept_event(r);
    n_sent++;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_addresses(input logic [7:0] ann, input logic [7:0] rec);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: CFG_ANN_ADDR, value: ann};
    do @(posedge clk_i); while (!cfg_if.ready);
    model.write_reg(CFG_ANN_ADDR, ann);
    cfg_if.data  <= '{index: CFG_REC_ADDR, value: rec};
    do @(posedge clk_i); while (!cfg_if.ready);
    model.write_reg(CFG_REC_ADDR, rec);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic directed_items();
    req_t r;
    send_item(rnd_req(REQ_STATUS));
    send_item(rnd_req(REQ_VERSION));
    r = rnd_req(REQ_VOLUME);
    r.entry_code = 16'hFFAB;
    send_item(r);
    send_item(play_req(16'h0000, 1'b0));
    send_item(ann_resp(RSP_UNKNOWN, 8'h00, 8'h00, 1'b0));
    // urgent with byte one zero: no emergency, one-word play goes out
    send_item(ann_resp(CMD_STATUS, 8'h00, ANN_IDLE, 1'b1));
    send_item(play_req(16'hFFFF, 1'b1));
    repeat (14) send_item(play_req(16'($urandom), 1'b0));
    // list full, this code is dropped
    send_item(play_req(16'h5555, 1'b0));
    send_item(ann_resp(CMD_STATUS, 8'($urandom), ANN_IDLE, 1'b0));
    send_item(ann_resp(CMD_STATUS, 8'hFF, ANN_IDLE, 1'b0));
    send_item(ann_resp(CMD_STATUS, 8'h01, ANN_PLAYING, 1'b1));
    send_item(ann_resp(CMD_STOP, 8'($urandom), 8'($urandom), 1'b0));
    r = rnd_req(REQ_RESPONSE);
    r.source_device = model.rec_addr;
    r.response_code = REC_START;
    send_item(r);
  endtask

  task automatic noise_item();
    req_t r;
    case ($urandom_range(0, 9))
      0: begin
        r = rnd_req(REQ_RESPONSE);
        r.source_device = model.rec_addr;
        case ($urandom_range(0, 2))
          0: r.response_code = REC_START;
          1: r.response_code = REC_STOP;
          default: ;
        endcase
      end
      1: r = rnd_req(REQ_RESPONSE);
      2: r = ann_resp(8'($urandom), 8'($urandom), pick_ann_state(), 1'($urandom));
      3: r = rnd_req(REQ_STOP);
      4: r = rnd_req(REQ_CLEAR);
      5: r = rnd_req(REQ_STATUS);
      6: r = rnd_req(REQ_VERSION);
      7: r = rnd_req(REQ_VOLUME);
      8: r = rnd_req(REQ_UNUSED);
      default: r = play_req(pick_code(), 1'($urandom));
    endcase
    send_item(r);
  endtask

  task automatic run_random(input int count);
    int target;
    int pick;
    logic [7:0] code;
    target = n_sent + count;
    while (n_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        // fill the list, then let the announcer answer so that play can go out
        repeat ($urandom_range(1, 4))
          send_item(play_req(pick_code(), $urandom_range(0, 5) == 0));
        repeat ($urandom_range(2, 6)) begin
          code = ($urandom_range(0, 3) == 0) ? 8'($urandom) : CMD_STATUS;
          send_item(ann_resp(code, 8'($urandom), pick_ann_state(),
                             $urandom_range(0, 7) == 0));
        end
      end else if (pick < 6) begin
        // announcer playing, then a stop is requested and retried
        send_item(ann_resp(CMD_STATUS, 8'($urandom), ANN_PLAYING, 1'b0));
        if ($urandom_range(0, 1) == 0) send_item(play_req(pick_code(), 1'($urandom)));
        else send_item(rnd_req(REQ_STOP));
        repeat ($urandom_range(2, 5)) begin
          case ($urandom_range(0, 2))
            0: send_item(ann_resp(CMD_STATUS, 8'($urandom), ANN_PLAYING,
                                  $urandom_range(0, 5) == 0));
            1: send_item(ann_resp(CMD_STOP, 8'($urandom), 8'($urandom), 1'($urandom)));
            default: send_item(ann_resp(8'($urandom), 8'($urandom), 8'($urandom),
                                        1'($urandom)));
          endcase
        end
      end else begin
        noise_item();
      end
    end
  endtask

  initial begin
    logic [7:0] ann_set [5];
    logic [7:0] rec_set [5];
    req_if.valid = 1'b0;
    req_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    ann_set = '{8'd1, 8'd0,   8'd255, 8'h5A, 8'($urandom)};
    rec_set = '{8'd2, 8'd255, 8'd0,   8'h5A, 8'($urandom)};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_items();
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        drain();
        write_addresses(ann_set[p], rec_set[p]);
      end
      calm = (p == 3);
      if (p == 2) hold_req = HOLD_CYCLES;
      if (p == 1) begin
        run_random(22);
        drain();
        run_random(22);
      end else begin
        run_random(44);
      end
    end
    drain();

    $display("Ran %0d input items giving %0d result items over five address settings,",
             model.items_seen, model.results_seen);
    $display("with %0d play commands and %0d emergency stops among them.",
             model.play_cmds, model.emerg_stops);
    if (model.errors == 0 && model.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- voice_announcer_command_retry.f -----
design/varc_pkg.sv
design/varc_intf.sv
design/voice_announcer_command_retry.sv
sim/tb_announcer_pkg.sv
sim/tb_top.sv
